[src/cpa_pkg.sv]
`timescale 1ns / 1ps

package cpa_pkg;

    // Fixed-point formats
    localparam int ANGLE_FRAC_BITS  = 24;
    localparam int RESULT_FRAC_BITS = 30;

    localparam int ANGLE_W = 32;
    localparam int COS_W   = 32;
    localparam int REM_W   = 32;
    localparam int DIV_W   = 34;
    localparam int Y30_W   = 31;
    localparam int SQ_W    = 2 * Y30_W;
    localparam int X2_W    = 32;
    localparam int ACC_W   = 32;
    localparam int PROD_W  = 64;

    localparam int ASHIFT  = 60 - ANGLE_FRAC_BITS;
    localparam int Y_SHIFT = 30 - ANGLE_FRAC_BITS;
    localparam int R_SHIFT = 30 - RESULT_FRAC_BITS;
    localparam int Q30     = 30;

    // Angle constants, Q60 and rounded to the angle format
    localparam logic [63:0] HALFPI_Q60 = 64'h1921FB54442D1847;
    localparam logic [63:0] PI_Q60     = 64'h3243F6A8885A308D;
    localparam logic [63:0] TWOPI_Q60  = 64'h6487ED5110B4611B;

    localparam logic [63:0] HALFPI    = (HALFPI_Q60 + (64'd1 << (ASHIFT - 1))) >> ASHIFT;
    localparam logic [63:0] PI        = (PI_Q60 + (64'd1 << (ASHIFT - 1))) >> ASHIFT;
    localparam logic [63:0] TWOPI     = (TWOPI_Q60 + (64'd1 << (ASHIFT - 1))) >> ASHIFT;
    localparam logic [63:0] THREEHALF = HALFPI + PI;

    // One remainder cell per quotient bit of |angle| / 2pi
    localparam int TWOPI_LOG = $clog2(TWOPI);
    localparam int REM_CELLS = (33 - TWOPI_LOG > 1) ? (33 - TWOPI_LOG) : 1;
    localparam logic [DIV_W-1:0] DIV_START = DIV_W'(TWOPI << (REM_CELLS - 1));

    // Polynomial coefficients, Q30
    localparam logic signed [ACC_W-1:0] COEF1 = 32'sd1073741774;
    localparam logic signed [ACC_W-1:0] COEF2 = -32'sd536869896;
    localparam logic signed [ACC_W-1:0] COEF3 = 32'sd44735933;
    localparam logic signed [ACC_W-1:0] COEF4 = -32'sd1487530;
    localparam logic signed [ACC_W-1:0] COEF5 = 32'sd24861;

    localparam int HORNER_CELLS = 4;
    localparam logic signed [ACC_W-1:0] HORNER_COEF [HORNER_CELLS] =
        '{COEF4, COEF3, COEF2, COEF1};

    localparam logic [63:0]        HALF_Q30 = 64'd1 << (Q30 - 1);
    localparam logic signed [63:0] COS_LIM  = 64'sd1 <<< RESULT_FRAC_BITS;

    typedef struct packed {
        logic [REM_W-1:0] r;
        logic [DIV_W-1:0] d;
    } rem_data_t;

    typedef struct packed {
        logic signed [ACC_W-1:0] acc;
        logic [X2_W-1:0]         x2;
        logic                    neg;
    } hrn_data_t;

    // Arithmetic shift right with round to nearest, ties away from zero
    function automatic logic signed [63:0] round_shift(input logic signed [63:0] v,
                                                       input int s);
        logic [63:0]        m;
        logic [63:0]        q;
        logic signed [63:0] res;
        m = v[63] ? (~v + 64'd1) : v;
        if (s == 0) begin
            res = v;
        end else begin
            q   = (m + (64'd1 << (s - 1))) >> s;
            res = v[63] ? $signed(~q + 64'd1) : $signed(q);
        end
        return res;
    endfunction

endpackage

[src/cpa_rem_cell.sv]
`timescale 1ns / 1ps

// One restoring step: subtract the current multiple of 2pi if it fits, halve it
module cpa_rem_cell (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                up_valid,
    output logic                up_ready,
    input  cpa_pkg::rem_data_t  up_data,
    output logic                dn_valid,
    input  logic                dn_ready,
    output cpa_pkg::rem_data_t  dn_data
);

    logic               valid_reg;
    cpa_pkg::rem_data_t data_reg;
    cpa_pkg::rem_data_t data_next;
    logic               fits;

    assign up_ready = !valid_reg || dn_ready;
    assign fits     = {{(cpa_pkg::DIV_W - cpa_pkg::REM_W){1'b0}}, up_data.r} >= up_data.d;

    always_comb
    begin
        data_next.r = fits ? cpa_pkg::REM_W'({{(cpa_pkg::DIV_W - cpa_pkg::REM_W){1'b0}},
                                              up_data.r} - up_data.d)
                           : up_data.r;
        data_next.d = up_data.d >> 1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (up_ready)
        begin
            valid_reg <= up_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (up_ready && up_valid)
        begin
            data_reg <= data_next;
        end
    end

    assign dn_valid = valid_reg;
    assign dn_data  = data_reg;

endmodule

[src/cpa_horner_cell.sv]
`timescale 1ns / 1ps

// One Horner step, acc = coef + round(acc * x2 >> 30), over two registers
module cpa_horner_cell (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic signed [cpa_pkg::ACC_W-1:0] coef,
    input  logic                           up_valid,
    output logic                           up_ready,
    input  cpa_pkg::hrn_data_t             up_data,
    output logic                           dn_valid,
    input  logic                           dn_ready,
    output cpa_pkg::hrn_data_t             dn_data
);

    logic                                 mul_valid_reg;
    logic                                 mul_ready;
    logic signed [cpa_pkg::PROD_W-1:0]    prod_reg;
    logic signed [cpa_pkg::PROD_W-1:0]    prod_next;
    logic signed [cpa_pkg::ACC_W+cpa_pkg::X2_W:0] prod_full;
    logic [cpa_pkg::X2_W-1:0]             x2_reg;
    logic                                 neg_reg;

    logic                                 add_valid_reg;
    cpa_pkg::hrn_data_t                   data_reg;
    cpa_pkg::hrn_data_t                   data_next;

    assign mul_ready = !add_valid_reg || dn_ready;
    assign up_ready  = !mul_valid_reg || mul_ready;

    assign prod_full = up_data.acc * $signed({1'b0, up_data.x2});
    assign prod_next = $signed(prod_full[cpa_pkg::PROD_W-1:0]);

    always_comb
    begin
        data_next.acc = coef + cpa_pkg::ACC_W'(cpa_pkg::round_shift(prod_reg, cpa_pkg::Q30));
        data_next.x2  = x2_reg;
        data_next.neg = neg_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mul_valid_reg <= 1'b0;
            add_valid_reg <= 1'b0;
        end
        else
        begin
            if (up_ready)
            begin
                mul_valid_reg <= up_valid;
            end
            if (mul_ready)
            begin
                add_valid_reg <= mul_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (up_ready && up_valid)
        begin
            prod_reg <= prod_next;
            x2_reg   <= up_data.x2;
            neg_reg  <= up_data.neg;
        end
        if (mul_ready && mul_valid_reg)
        begin
            data_reg <= data_next;
        end
    end

    assign dn_valid = add_valid_reg;
    assign dn_data  = data_reg;

endmodule

[src/cosine_poly_approx_top.sv]
`timescale 1ns / 1ps

// Cosine of a signed Q24 angle in radians, returned as signed Q30 and
// saturated to +/-1.0. The block is a fully pipelined row of cells and
// takes one item per clock unless the output stalls. In order: the |angle|
// register, one remainder cell per quotient bit of |angle| / 2pi (6
// cells), the fold into [0, pi/2], the square and rounded x^2 registers,
// a product and an add register per Horner cell (four cells, each one
// 32x33 multiplier) and one output register. Every stage has its own
// valid bit and only stalls when the stage after it is full, so new items
// keep entering while a result waits on out_ready, until the row fills.
module cosine_poly_approx_top (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  logic signed [cpa_pkg::ANGLE_W-1:0] angle,
    output logic                              out_valid,
    input  logic                              out_ready,
    output logic signed [cpa_pkg::COS_W-1:0]  cosine
);

    localparam int NR = cpa_pkg::REM_CELLS;
    localparam int NH = cpa_pkg::HORNER_CELLS;

    // Stage: magnitude of the angle (cos is even)
    logic                       abs_valid_reg;
    logic                       abs_ready;
    logic [cpa_pkg::REM_W-1:0]  mag_reg;
    logic [cpa_pkg::REM_W-1:0]  mag_next;

    // Remainder chain
    logic                rem_valid [NR+1];
    logic                rem_ready [NR+1];
    cpa_pkg::rem_data_t  rem_data  [NR+1];

    // Stage: fold into [0, pi/2]
    logic                        fold_valid_reg;
    logic                        fold_ready;
    logic [cpa_pkg::Y30_W-1:0]   y30_reg;
    logic [cpa_pkg::Y30_W-1:0]   y30_next;
    logic                        fold_neg_reg;
    logic                        fold_neg_next;
    logic [63:0]                 r64;
    logic [63:0]                 y64;

    // Stage: square product
    logic                        sq_valid_reg;
    logic                        sq_ready;
    logic [cpa_pkg::SQ_W-1:0]    sq_reg;
    logic [cpa_pkg::SQ_W-1:0]    sq_next;
    logic                        sq_neg_reg;

    // Stage: rounded x^2, seeds the Horner chain
    logic                        x2_valid_reg;
    logic                        x2_ready;
    cpa_pkg::hrn_data_t          x2_data_reg;
    cpa_pkg::hrn_data_t          x2_data_next;

    // Horner chain
    logic                hrn_valid [NH+1];
    logic                hrn_ready [NH+1];
    cpa_pkg::hrn_data_t  hrn_data  [NH+1];

    // Output register
    logic                              out_valid_reg;
    logic                              out_stage_ready;
    logic signed [cpa_pkg::COS_W-1:0]  cosine_reg;
    logic signed [cpa_pkg::COS_W-1:0]  cosine_next;
    logic signed [63:0]                acc_ext;
    logic signed [63:0]                acc_signed;
    logic signed [63:0]                acc_scaled;

    // ---------------- magnitude ----------------
    assign abs_ready = !abs_valid_reg || rem_ready[0];
    assign in_ready  = abs_ready;
    // The most negative angle wraps to 2^31, which the unsigned field holds
    assign mag_next  = angle[cpa_pkg::ANGLE_W-1] ? (~$unsigned(angle) + 32'd1)
                                                 : $unsigned(angle);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            abs_valid_reg <= 1'b0;
        end
        else if (abs_ready)
        begin
            abs_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (abs_ready && in_valid)
        begin
            mag_reg <= mag_next;
        end
    end

    // ---------------- |angle| mod 2pi ----------------
    // Each cell tries the next lower multiple 2pi * 2^k, from the top bit down
    assign rem_valid[0]  = abs_valid_reg;
    assign rem_data[0].r = mag_reg;
    assign rem_data[0].d = cpa_pkg::DIV_START;

    for (genvar i = 0; i < NR; i++)
    begin : g_rem
        cpa_rem_cell u_rem (
            .clk      (clk),
            .rst_n    (rst_n),
            .up_valid (rem_valid[i]),
            .up_ready (rem_ready[i]),
            .up_data  (rem_data[i]),
            .dn_valid (rem_valid[i+1]),
            .dn_ready (rem_ready[i+1]),
            .dn_data  (rem_data[i+1])
        );
    end

    // ---------------- quadrant fold ----------------
    // A reduced angle sitting on a boundary goes to the higher quadrant
    assign rem_ready[NR] = fold_ready;
    assign fold_ready    = !fold_valid_reg || sq_ready;
    assign r64           = 64'(rem_data[NR].r);

    always_comb
    begin
        if (r64 < cpa_pkg::HALFPI)
        begin
            y64           = r64;
            fold_neg_next = 1'b0;
        end
        else if (r64 < cpa_pkg::PI)
        begin
            y64           = cpa_pkg::PI - r64;
            fold_neg_next = 1'b1;
        end
        else if (r64 < cpa_pkg::THREEHALF)
        begin
            y64           = r64 - cpa_pkg::PI;
            fold_neg_next = 1'b1;
        end
        else
        begin
            y64           = cpa_pkg::TWOPI - r64;
            fold_neg_next = 1'b0;
        end
        // Move to Q30; the folded angle is at most PI - HALFPI, so it fits Y30_W
        y30_next = cpa_pkg::Y30_W'(y64 << cpa_pkg::Y_SHIFT);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fold_valid_reg <= 1'b0;
        end
        else if (fold_ready)
        begin
            fold_valid_reg <= rem_valid[NR];
        end
    end

    always_ff @(posedge clk)
    begin
        if (fold_ready && rem_valid[NR])
        begin
            y30_reg      <= y30_next;
            fold_neg_reg <= fold_neg_next;
        end
    end

    // ---------------- square ----------------
    assign x2_ready = !x2_valid_reg || hrn_ready[0];
    assign sq_ready = !sq_valid_reg || x2_ready;
    assign sq_next  = y30_reg * y30_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sq_valid_reg <= 1'b0;
            x2_valid_reg <= 1'b0;
        end
        else
        begin
            if (sq_ready)
            begin
                sq_valid_reg <= fold_valid_reg;
            end
            if (x2_ready)
            begin
                x2_valid_reg <= sq_valid_reg;
            end
        end
    end

    always_comb
    begin
        x2_data_next.acc = cpa_pkg::COEF5;
        x2_data_next.x2  = cpa_pkg::X2_W'((64'(sq_reg) + cpa_pkg::HALF_Q30) >> cpa_pkg::Q30);
        x2_data_next.neg = sq_neg_reg;
    end

    always_ff @(posedge clk)
    begin
        if (sq_ready && fold_valid_reg)
        begin
            sq_reg     <= sq_next;
            sq_neg_reg <= fold_neg_reg;
        end
        if (x2_ready && sq_valid_reg)
        begin
            x2_data_reg <= x2_data_next;
        end
    end

    // ---------------- Horner chain ----------------
    assign hrn_valid[0] = x2_valid_reg;
    assign hrn_data[0]  = x2_data_reg;

    for (genvar j = 0; j < NH; j++)
    begin : g_hrn
        cpa_horner_cell u_hrn (
            .clk      (clk),
            .rst_n    (rst_n),
            .coef     (cpa_pkg::HORNER_COEF[j]),
            .up_valid (hrn_valid[j]),
            .up_ready (hrn_ready[j]),
            .up_data  (hrn_data[j]),
            .dn_valid (hrn_valid[j+1]),
            .dn_ready (hrn_ready[j+1]),
            .dn_data  (hrn_data[j+1])
        );
    end

    // ---------------- sign, scale, saturate ----------------
    assign out_stage_ready = !out_valid_reg || out_ready;
    assign hrn_ready[NH]   = out_stage_ready;

    always_comb
    begin
        acc_ext    = 64'(hrn_data[NH].acc);
        acc_signed = hrn_data[NH].neg ? -acc_ext : acc_ext;
        acc_scaled = cpa_pkg::round_shift(acc_signed, cpa_pkg::R_SHIFT);
        if (acc_scaled > cpa_pkg::COS_LIM)
        begin
            cosine_next = cpa_pkg::COS_W'(cpa_pkg::COS_LIM);
        end
        else if (acc_scaled < -cpa_pkg::COS_LIM)
        begin
            cosine_next = cpa_pkg::COS_W'(-cpa_pkg::COS_LIM);
        end
        else
        begin
            cosine_next = cpa_pkg::COS_W'(acc_scaled);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_stage_ready)
        begin
            out_valid_reg <= hrn_valid[NH];
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_stage_ready && hrn_valid[NH])
        begin
            cosine_reg <= cosine_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign cosine    = cosine_reg;

endmodule

[sim/cosine_poly_checker.sv]
`timescale 1ns / 1ps

module cosine_poly_checker (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               in_valid,
    input  logic                               in_ready,
    input  logic signed [cpa_pkg::ANGLE_W-1:0] angle,
    input  logic                               out_valid,
    input  logic                               out_ready,
    input  logic signed [cpa_pkg::COS_W-1:0]   cosine,
    output int                                 mismatches,
    output int                                 cosines_left,
    output int                                 cosines_seen
);

    localparam int   A_FRAC = cpa_pkg::ANGLE_FRAC_BITS;
    localparam int   R_FRAC = cpa_pkg::RESULT_FRAC_BITS;
    localparam int   A_SH   = 60 - A_FRAC;
    localparam int   MAX_REPORTS = 10;

    localparam longint unsigned HALFPI_L =
        (64'h1921FB54442D1847 + (64'd1 << (A_SH - 1))) >> A_SH;
    localparam longint unsigned PI_L =
        (64'h3243F6A8885A308D + (64'd1 << (A_SH - 1))) >> A_SH;
    localparam longint unsigned TWOPI_L =
        (64'h6487ED5110B4611B + (64'd1 << (A_SH - 1))) >> A_SH;
    localparam longint unsigned THREEHALF_L = HALFPI_L + PI_L;

    localparam longint C1 = 1073741774;
    localparam longint C2 = -536869896;
    localparam longint C3 = 44735933;
    localparam longint C4 = -1487530;
    localparam longint C5 = 24861;

    logic signed [cpa_pkg::COS_W-1:0] cosine_expected_q[$];

    // Shift right, round to nearest, ties away from zero
    function automatic longint round_half_away(input longint v, input int s);
        longint mag;
        longint q;
        if (s == 0)
            return v;
        mag = (v < 0) ? -v : v;
        q   = (mag + (64'sd1 <<< (s - 1))) >>> s;
        return (v < 0) ? -q : q;
    endfunction

    function automatic logic signed [cpa_pkg::COS_W-1:0] cosine_of_angle(
        input logic signed [cpa_pkg::ANGLE_W-1:0] a);
        longint          ang;
        longint unsigned mag;
        longint unsigned r;
        longint unsigned y;
        longint unsigned y30;
        longint          x2;
        longint          acc;
        longint          lim;
        logic            flip;
        ang  = a;
        mag  = (ang < 0) ? longint'(-ang) : longint'(ang);
        r    = mag % TWOPI_L;
        lim  = 64'sd1 <<< R_FRAC;
        // Fold into [0, pi/2]; a boundary value goes to the upper quadrant
        if (r < HALFPI_L) begin
            y    = r;
            flip = 1'b0;
        end else if (r < PI_L) begin
            y    = PI_L - r;
            flip = 1'b1;
        end else if (r < THREEHALF_L) begin
            y    = r - PI_L;
            flip = 1'b1;
        end else begin
            y    = TWOPI_L - r;
            flip = 1'b0;
        end
        y30 = y << (30 - A_FRAC);
        x2  = longint'((y30 * y30 + (64'd1 << 29)) >> 30);
        acc = C5;
        acc = C4 + round_half_away(acc * x2, 30);
        acc = C3 + round_half_away(acc * x2, 30);
        acc = C2 + round_half_away(acc * x2, 30);
        acc = C1 + round_half_away(acc * x2, 30);
        if (flip)
            acc = -acc;
        acc = round_half_away(acc, 30 - R_FRAC);
        if (acc > lim)
            acc = lim;
        if (acc < -lim)
            acc = -lim;
        return acc[cpa_pkg::COS_W-1:0];
    endfunction

    initial
    begin
        mismatches   = 0;
        cosines_left = 0;
        cosines_seen = 0;
    end

    always @(posedge clk)
    begin
        logic signed [cpa_pkg::COS_W-1:0] want;
        if (rst_n)
        begin
            if (in_valid && in_ready)
                cosine_expected_q.push_back(cosine_of_angle(angle));
            if (out_valid && out_ready)
            begin
                cosines_seen = cosines_seen + 1;
                if (cosine_expected_q.size() == 0)
                begin
                    if (mismatches < MAX_REPORTS)
                        $display("%0t: cosine %0d arrived with nothing pending",
                                 $time, cosine);
                    mismatches = mismatches + 1;
                end
                else
                begin
                    want = cosine_expected_q.pop_front();
                    if (cosine !== want)
                    begin
                        if (mismatches < MAX_REPORTS)
                            $display("%0t: cosine mismatch: expected %0d, got %0d",
                                     $time, want, cosine);
                        mismatches = mismatches + 1;
                    end
                end
            end
            cosines_left = cosine_expected_q.size();
        end
    end

endmodule

[sim/cosine_poly_approx_top_tb.sv]
`timescale 1ns / 1ps

module cosine_poly_approx_top_tb;

    localparam int A_SH        = 60 - cpa_pkg::ANGLE_FRAC_BITS;
    localparam int N_RANDOM    = 880;
    localparam int HOLD_CYCLES = 300;
    localparam int DRAIN_TAIL  = 40;
    localparam int CYCLE_LIMIT = 200000;

    // Quadrant boundaries in the angle format, for aiming the stimulus
    localparam longint HALFPI_A =
        longint'((64'h1921FB54442D1847 + (64'd1 << (A_SH - 1))) >> A_SH);
    localparam longint PI_A =
        longint'((64'h3243F6A8885A308D + (64'd1 << (A_SH - 1))) >> A_SH);
    localparam longint TWOPI_A =
        longint'((64'h6487ED5110B4611B + (64'd1 << (A_SH - 1))) >> A_SH);
    localparam longint THREEHALF_A = HALFPI_A + PI_A;

    logic                               clk = 1'b0;
    logic                               rst_n = 1'b0;
    logic                               in_valid = 1'b0;
    logic                               in_ready;
    logic signed [cpa_pkg::ANGLE_W-1:0] angle = '0;
    logic                               out_valid;
    logic                               out_ready = 1'b0;
    logic signed [cpa_pkg::COS_W-1:0]   cosine;

    int   mismatches;
    int   cosines_left;
    int   cosines_seen;
    int   angles_sent = 0;
    int   cycles = 0;
    int   send_idle_pct = 7;
    int   recv_idle_pct = 71;
    logic hold_off = 1'b0;
    logic pressure_go = 1'b0;

    cosine_poly_approx_top dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .angle     (angle),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .cosine    (cosine)
    );

    // Watch both channels, predict every cosine and compare in order
    cosine_poly_checker u_checker (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .angle        (angle),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .cosine       (cosine),
        .mismatches   (mismatches),
        .cosines_left (cosines_left),
        .cosines_seen (cosines_seen)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // Abort a hung run
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d cosines still pending",
                     cycles, cosines_left);
            $display("[cosine_poly_approx_top] ERROR");
            $finish;
        end
    end

    // Receiver: drop ready at random, and hold it low for the whole
    // pressure stretch so the pipeline fills and stalls the input side
    always @(posedge clk)
    begin
        if (!rst_n)
            out_ready <= 1'b0;
        else
            out_ready <= !hold_off && ($urandom_range(0, 99) >= recv_idle_pct);
    end

    // Pressure stretch, counted in cycles on its own
    initial
    begin
        wait (pressure_go);
        @(posedge clk);
        hold_off <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_off <= 1'b0;
    end

    // Offer one item and hold it until accepted; idle first at random
    task automatic send_angle(input longint a);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        angle    <= a[cpa_pkg::ANGLE_W-1:0];
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        angles_sent = angles_sent + 1;
    endtask

    // Random angle: mostly aimed at quadrant edges and small magnitudes,
    // the rest anywhere in the 32-bit range
    function automatic longint random_angle();
        longint base;
        longint v;
        int     pick;
        pick = $urandom_range(0, 3);
        case (pick)
            0: v = longint'($signed($urandom));
            1: v = longint'($urandom_range(0, 32'(4 * TWOPI_A)));
            default:
            begin
                case ($urandom_range(0, 3))
                    0: base = 0;
                    1: base = HALFPI_A;
                    2: base = PI_A;
                    default: base = THREEHALF_A;
                endcase
                v = $urandom_range(0, 19) * TWOPI_A + base
                    + longint'($urandom_range(0, 6)) - 3;
                if (v < 0)
                    v = 0;
            end
        endcase
        if ($urandom_range(0, 1) == 1)
            v = -v;
        if (v > 64'sd2147483647)
            v = 64'sd2147483647;
        if (v < -64'sd2147483648)
            v = -64'sd2147483648;
        return v;
    endfunction

    initial
    begin
        longint edge_list[$];
        int     phase_len;
        rst_n <= 1'b0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: range extremes, quadrant edges, several turns out
        edge_list = '{0, 1, -1, 64'sd2147483647, -64'sd2147483648,
                      HALFPI_A - 1, HALFPI_A, HALFPI_A + 1,
                      PI_A - 1, PI_A, PI_A + 1,
                      THREEHALF_A - 1, THREEHALF_A, THREEHALF_A + 1,
                      TWOPI_A - 1, TWOPI_A, TWOPI_A + 1,
                      -HALFPI_A, -PI_A, -THREEHALF_A, -TWOPI_A,
                      20 * TWOPI_A, 20 * TWOPI_A - 1,
                      19 * TWOPI_A + THREEHALF_A, -(13 * TWOPI_A + PI_A)};
        foreach (edge_list[i])
            send_angle(edge_list[i]);

        // Random part in three idle mixes
        phase_len = N_RANDOM / 3;
        for (int n = 0; n < N_RANDOM; n++)
        begin
            if (n == phase_len)
            begin
                send_idle_pct = 71;
                recv_idle_pct <= 7;
            end
            else if (n == 2 * phase_len)
            begin
                send_idle_pct = 0;
                recv_idle_pct <= 0;
                pressure_go   <= 1'b1;
            end
            send_angle(random_angle());
        end
        in_valid <= 1'b0;

        // Drain, then give any stray result time to show up
        @(posedge clk);
        wait (cosines_left == 0);
        repeat (DRAIN_TAIL) @(posedge clk);

        $display("covered %0d angles: range extremes, quadrant edges, random turns",
                 angles_sent);
        $display("idle mixes 7/71, 71/7, 0/0 and a %0d-cycle output stall; %0d checked",
                 HOLD_CYCLES, cosines_seen);
        if (mismatches == 0 && cosines_left == 0)
            $display("[cosine_poly_approx_top] OK");
        else
            $display("[cosine_poly_approx_top] ERROR");
        $finish;
    end

endmodule

[sim.f]
src/cpa_pkg.sv
src/cpa_rem_cell.sv
src/cpa_horner_cell.sv
src/cosine_poly_approx_top.sv
sim/cosine_poly_checker.sv
sim/cosine_poly_approx_top_tb.sv
